/* rtl/hssm_pkg.sv */
// ----------------------------------------------------------------------------
// hssm_pkg: shared types and constants of the half-step stepper mover
// Field widths, operation codes, register indexes, reset values, the
// half-step coil table and the structs passed between the block's modules.
// ----------------------------------------------------------------------------
package hssm_pkg;

  // Field and state widths
  localparam int SLOT_W   = 8;
  localparam int SPS_W    = 32;
  localparam int FRIC_W   = 16;
  localparam int DELAY_W  = 16;
  localparam int STEPS_W  = 20;
  localparam int COIL_W   = 4;
  localparam int PHASE_W  = 3;
  localparam int FRAC_W   = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Shared multiplier widths
  localparam int MUL_A_W  = 32;
  localparam int MUL_B_W  = 16;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int BASE_W   = SPS_W + SLOT_W;
  localparam int ACC_W    = BASE_W + FRIC_W;
  localparam int TOTAL_W  = 25;
  localparam int BONUS_W  = ACC_W - 32;

  localparam logic [STEPS_W-1:0] STEPS_MAX = '1;

  // Operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_MOVE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_SLOT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRICTION       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DELAY     = 2'd2;

  // Register reset values
  localparam logic [SPS_W-1:0]   SPS_RESET   = 32'd133555814;
  localparam logic [FRIC_W-1:0]  FRIC_RESET  = 16'd16384;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd2;

  // Control toward the motion state
  typedef struct packed {
    logic               tick;
    logic               load;
    logic [STEPS_W-1:0] load_steps;
  } drv_ctrl_t;

  // Status from the motion state
  typedef struct packed {
    logic [COIL_W-1:0]  coil;
    logic               busy;
    logic [STEPS_W-1:0] steps;
  } drv_stat_t;

  // Accumulator control of the shared multiplier
  typedef struct packed {
    logic acc_en;
    logic acc_init;
    logic acc_shift;
  } mac_ctl_t;

  // Half-step coil pattern for a phase
  function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] idx);
    logic [COIL_W-1:0] pat;
    unique case (idx)
      3'd0: pat = 4'h1;
      3'd1: pat = 4'h3;
      3'd2: pat = 4'h2;
      3'd3: pat = 4'h6;
      3'd4: pat = 4'h4;
      3'd5: pat = 4'hC;
      3'd6: pat = 4'h8;
      3'd7: pat = 4'h9;
      default: pat = '0;
    endcase
    return pat;
  endfunction

endpackage

/* rtl/hssm_mac.sv */
// ----------------------------------------------------------------------------
// hssm_mac: shared multiply-accumulate unit
// One 32x16 multiplier with a product register, followed by an accumulator
// that can start from the rounding constant or add the product shifted up
// by 32 bits.
// ----------------------------------------------------------------------------
module hssm_mac (
  input  logic                              clk,
  input  logic [hssm_pkg::MUL_A_W-1:0]      op_a,
  input  logic [hssm_pkg::MUL_B_W-1:0]      op_b,
  input  hssm_pkg::mac_ctl_t                ctl,
  output logic [hssm_pkg::PROD_W-1:0]       prod,
  output logic [hssm_pkg::ACC_W-1:0]        acc
);

  localparam logic [hssm_pkg::ACC_W-1:0] ROUND_HALF = hssm_pkg::ACC_W'(64'h8000_0000);

  logic [hssm_pkg::PROD_W-1:0] prod_r;
  logic [hssm_pkg::ACC_W-1:0]  acc_r;
  logic [hssm_pkg::ACC_W-1:0]  acc_nxt;
  logic [hssm_pkg::ACC_W-1:0]  addend;

  // Align the product: plain, or shifted up by one word
  always_comb begin
    if (ctl.acc_shift) begin
      addend = {prod_r[hssm_pkg::ACC_W-33:0], 32'd0};
    end else begin
      addend = hssm_pkg::ACC_W'(prod_r);
    end
    acc_nxt = (ctl.acc_init ? ROUND_HALF : acc_r) + addend;
  end

  // Multiply every cycle; accumulate on request
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (ctl.acc_en) begin
      acc_r <= acc_nxt;
    end
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule

/* rtl/hssm_drive.sv */
// ----------------------------------------------------------------------------
// hssm_drive: motion state of the stepper
// Holds the phase index, remaining half-steps, hold counter and coil
// register; plays one half-step per delay period on ticks and loads moves.
// ----------------------------------------------------------------------------
module hssm_drive (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [hssm_pkg::DELAY_W-1:0]      step_delay,
  input  hssm_pkg::drv_ctrl_t               ctrl,
  output hssm_pkg::drv_stat_t               stat
);

  logic [hssm_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [hssm_pkg::STEPS_W-1:0] rem_r, rem_nxt;
  logic [hssm_pkg::DELAY_W-1:0] hold_r, hold_nxt;
  logic [hssm_pkg::COIL_W-1:0]  coil_r, coil_nxt;
  logic [hssm_pkg::DELAY_W-1:0] hold_dec;
  logic                         busy;

  assign busy     = (rem_r != '0) || (hold_r != '0);
  assign hold_dec = (hold_r != '0) ? hold_r - 1'b1 : hold_r;

  // Next motion state
  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    hold_nxt  = hold_r;
    coil_nxt  = coil_r;
    if (ctrl.load) begin
      rem_nxt  = ctrl.load_steps;
      hold_nxt = '0;
      if (ctrl.load_steps != '0) begin
        coil_nxt  = hssm_pkg::coil_pattern(phase_r);
        phase_nxt = phase_r + 1'b1;
        rem_nxt   = ctrl.load_steps - 1'b1;
        hold_nxt  = step_delay;
      end else begin
        coil_nxt = '0;
      end
    end else if (ctrl.tick && busy) begin
      hold_nxt = hold_dec;
      if (hold_dec == '0) begin
        if (rem_r != '0) begin
          coil_nxt  = hssm_pkg::coil_pattern(phase_r);
          phase_nxt = phase_r + 1'b1;
          rem_nxt   = rem_r - 1'b1;
          hold_nxt  = step_delay;
        end else begin
          coil_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      rem_r   <= '0;
      hold_r  <= '0;
      coil_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      hold_r  <= hold_nxt;
      coil_r  <= coil_nxt;
    end
  end

  assign stat.coil  = coil_r;
  assign stat.busy  = busy;
  assign stat.steps = rem_r;

endmodule

/* rtl/half_step_stepper_mover.sv */
// ----------------------------------------------------------------------------
// half_step_stepper_mover: half-step stepper sequencer with step accumulator
//
// Input channel (in_valid / in_stall): in_operation selects a time tick or a
// move command of in_slot_count slots. Every accepted item gives exactly one
// result on the output channel (out_valid / out_stall): the coil pattern,
// the busy flag and the half-steps still to be issued.
// A tick, or a move while busy (ignored), goes through ST_REPLY into the
// output register. A move goes through ST_BASE_MUL, ST_LO_MUL, ST_HI_MUL,
// ST_HI_ACC, ST_FINISH and ST_REPLY: one 32x16 multiplier runs three times
// (slots times steps per slot, then the low and high words of that product
// times the friction fraction), the rounding shares the low-word cycle, and
// the friction accumulate and the saturating add take their own cycles.
// A new item is taken once the sequencer is back in idle, even while a result
// still waits; a stalled result holds in the output register and the next
// one waits in the sequencer, stretching in_stall, until it is taken.
// Reset (rst_n low, synchronous) loads the register defaults, stops the
// coils, clears the phase, fraction and step state and empties the output.
// Configuration writes go through cfg_we / cfg_index / cfg_data; the user
// makes them only while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module half_step_stepper_mover (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_operation,
  input  logic [hssm_pkg::SLOT_W-1:0]          in_slot_count,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [hssm_pkg::COIL_W-1:0]          out_coil_drive,
  output logic                                 out_busy_res,
  output logic [hssm_pkg::STEPS_W-1:0]         out_steps_left,
  input  logic                                 cfg_we,
  input  logic [hssm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hssm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE_MUL,
    ST_LO_MUL,
    ST_HI_MUL,
    ST_HI_ACC,
    ST_FINISH,
    ST_REPLY
  } state_t;

  state_t state_r, state_nxt;

  logic [hssm_pkg::SPS_W-1:0]   sps_r;
  logic [hssm_pkg::FRIC_W-1:0]  fric_r;
  logic [hssm_pkg::DELAY_W-1:0] delay_r;

  logic [hssm_pkg::SLOT_W-1:0]  slots_r, slots_nxt;
  logic [hssm_pkg::BASE_W-1:0]  base_r, base_nxt;
  logic [hssm_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic [hssm_pkg::FRAC_W-1:0]  frac_r, frac_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [hssm_pkg::COIL_W-1:0]  out_coil_r, out_coil_nxt;
  logic                         out_busy_r, out_busy_nxt;
  logic [hssm_pkg::STEPS_W-1:0] out_steps_r, out_steps_nxt;

  logic [hssm_pkg::MUL_A_W-1:0] mul_a;
  logic [hssm_pkg::MUL_B_W-1:0] mul_b;
  hssm_pkg::mac_ctl_t           mac_ctl;
  logic [hssm_pkg::PROD_W-1:0]  prod;
  logic [hssm_pkg::ACC_W-1:0]   acc;

  hssm_pkg::drv_ctrl_t          drv_ctrl;
  hssm_pkg::drv_stat_t          drv_stat;

  logic                         in_xfer;
  logic                         out_free;
  logic signed [hssm_pkg::BASE_W+1:0] round_sum;
  logic [hssm_pkg::TOTAL_W:0]   sum_total;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sps_r   <= hssm_pkg::SPS_RESET;
      fric_r  <= hssm_pkg::FRIC_RESET;
      delay_r <= hssm_pkg::DELAY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hssm_pkg::REG_STEPS_PER_SLOT: sps_r   <= cfg_data;
        hssm_pkg::REG_FRICTION:       fric_r  <= cfg_data[hssm_pkg::FRIC_W-1:0];
        hssm_pkg::REG_STEP_DELAY:     delay_r <= cfg_data[hssm_pkg::DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Round slots * steps + carried fraction to whole half-steps
  assign round_sum = $signed({2'b00, prod[hssm_pkg::BASE_W-1:0]})
                   + (hssm_pkg::BASE_W+2)'($signed(frac_r))
                   + (hssm_pkg::BASE_W+2)'(32768);

  // Add the friction bonus to the rounded count
  assign sum_total = (hssm_pkg::TOTAL_W+1)'(total_r)
                   + (hssm_pkg::TOTAL_W+1)'(acc[hssm_pkg::ACC_W-1:32]);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    slots_nxt     = slots_r;
    base_nxt      = base_r;
    total_nxt     = total_r;
    frac_nxt      = frac_r;
    out_valid_nxt = out_valid_r;
    out_coil_nxt  = out_coil_r;
    out_busy_nxt  = out_busy_r;
    out_steps_nxt = out_steps_r;
    mul_a         = sps_r;
    mul_b         = hssm_pkg::MUL_B_W'(slots_r);
    mac_ctl       = '0;
    drv_ctrl      = '0;

    // drop the result once it is taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_operation == hssm_pkg::OP_TICK) begin
            drv_ctrl.tick = 1'b1;
            state_nxt     = ST_REPLY;
          end else if (drv_stat.busy) begin
            state_nxt = ST_REPLY;
          end else begin
            slots_nxt = in_slot_count;
            state_nxt = ST_BASE_MUL;
          end
        end
      end
      ST_BASE_MUL: begin
        mul_a     = sps_r;
        mul_b     = hssm_pkg::MUL_B_W'(slots_r);
        state_nxt = ST_LO_MUL;
      end
      ST_LO_MUL: begin
        mul_a    = prod[hssm_pkg::MUL_A_W-1:0];
        mul_b    = fric_r;
        base_nxt = prod[hssm_pkg::BASE_W-1:0];
        if (round_sum < 0) begin
          total_nxt = '0;
          frac_nxt  = round_sum[hssm_pkg::FRAC_W-1:0] - hssm_pkg::FRAC_W'(32768);
        end else begin
          total_nxt = round_sum[16 +: hssm_pkg::TOTAL_W];
          frac_nxt  = {1'b0, round_sum[15:0]} - hssm_pkg::FRAC_W'(32768);
        end
        state_nxt = ST_HI_MUL;
      end
      ST_HI_MUL: begin
        mul_a = hssm_pkg::MUL_A_W'(base_r[hssm_pkg::BASE_W-1:hssm_pkg::MUL_A_W]);
        mul_b = fric_r;
        mac_ctl.acc_en   = 1'b1;
        mac_ctl.acc_init = 1'b1;
        state_nxt = ST_HI_ACC;
      end
      ST_HI_ACC: begin
        mac_ctl.acc_en    = 1'b1;
        mac_ctl.acc_shift = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        drv_ctrl.load = 1'b1;
        if (sum_total > (hssm_pkg::TOTAL_W+1)'(hssm_pkg::STEPS_MAX)) begin
          drv_ctrl.load_steps = hssm_pkg::STEPS_MAX;
        end else begin
          drv_ctrl.load_steps = sum_total[hssm_pkg::STEPS_W-1:0];
        end
        state_nxt = ST_REPLY;
      end
      ST_REPLY: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_coil_nxt  = drv_stat.coil;
          out_busy_nxt  = drv_stat.busy;
          out_steps_nxt = drv_stat.steps;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State, carried fraction, working registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      frac_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      frac_r      <= frac_nxt;
      out_valid_r <= out_valid_nxt;
    end
    slots_r     <= slots_nxt;
    base_r      <= base_nxt;
    total_r     <= total_nxt;
    out_coil_r  <= out_coil_nxt;
    out_busy_r  <= out_busy_nxt;
    out_steps_r <= out_steps_nxt;
  end

  hssm_mac u_mac (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .ctl  (mac_ctl),
    .prod (prod),
    .acc  (acc)
  );

  hssm_drive u_drive (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_delay (delay_r),
    .ctrl       (drv_ctrl),
    .stat       (drv_stat)
  );

  assign out_valid      = out_valid_r;
  assign out_coil_drive = out_coil_r;
  assign out_busy_res   = out_busy_r;
  assign out_steps_left = out_steps_r;

endmodule
